[rtl/s1h_pkg.sv]
// shared types, constants and round functions of the sha-1 stream hasher
`default_nettype none

package s1h_pkg;

    localparam int BANK_WORDS = 16;
    localparam int BUF_WORDS  = 2 * BANK_WORDS;
    localparam int BUF_AW     = $clog2(BUF_WORDS);
    localparam int NUM_H      = 5;
    localparam int H_AW       = $clog2(NUM_H);
    localparam int ROUNDS     = 80;
    localparam int RND_W      = $clog2(ROUNDS);

    localparam logic [H_AW-1:0]  LAST_WORD = H_AW'(NUM_H - 1);
    localparam logic [7:0]       PAD_MARK  = 8'h80;
    localparam logic [5:0]       LEN_POS   = 6'd56;
    localparam logic [5:0]       BLOCK_END = 6'd63;

    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    // write of one message byte into the block buffer
    typedef struct packed {
        logic       en;
        logic       bank;
        logic [5:0] pos;
        logic [7:0] data;
    } buf_wr_t;

    // commands to the compression core
    typedef struct packed {
        logic start;
        logic bank;
        logic restart;
    } core_ctrl_t;

    // status of the compression core
    typedef struct packed {
        logic idle;
        logic done;
    } core_stat_t;

    function automatic logic [31:0] init_word(input logic [H_AW-1:0] i);
        logic [31:0] v;
        case (i)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hefcdab89;
            3'd2:    v = 32'h98badcfe;
            3'd3:    v = 32'h10325476;
            3'd4:    v = 32'hc3d2e1f0;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_f(input logic [RND_W-1:0] t,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] v;
        if (t < RND_W'(20)) begin
            v = (b & c) | (~b & d);
        end else if (t < RND_W'(40)) begin
            v = b ^ c ^ d;
        end else if (t < RND_W'(60)) begin
            v = (b & c) | (b & d) | (c & d);
        end else begin
            v = b ^ c ^ d;
        end
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [RND_W-1:0] t);
        logic [31:0] v;
        if (t < RND_W'(20)) begin
            v = K_0;
        end else if (t < RND_W'(40)) begin
            v = K_1;
        end else if (t < RND_W'(60)) begin
            v = K_2;
        end else begin
            v = K_3;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/sha1_stream_hasher.sv]
// top level of the sha-1 stream hasher: byte intake, padding, digest output
`default_nettype none

// sha-1 over a byte stream. each input word carries one message byte in
// s_tdata[7:0] with s_tuser low, or a finish request with s_tuser high
// (s_tdata ignored). bytes are packed into a two-bank 64-byte block buffer;
// a full bank is handed to the compression core while the other bank fills,
// so byte words keep being taken as long as the bank being filled is free.
// the core works a block as a start, a chaining load, 80 rounds at one round
// per cycle and a write-back, and the round loop sets the rate of a long
// message. finish appends 0x80, zeros and the 64-bit big-endian bit length
// one byte per cycle while the bank being filled is free, waits for the
// last one or two compressions, then emits the five digest words, H0 first,
// each read in S_RD, captured in S_CAP and held in S_WAIT until m_tready;
// m_tlast marks H4. no input is taken from finish until the last digest
// word leaves; the hasher then restarts from the standard initial values.
// the chaining memory needs no clearing pass after reset.
module sha1_stream_hasher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tuser,   // kind: 0 byte, 1 finish
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // word_index [2:0], digest_word [34:3], zeros
    output logic             m_tlast    // last digest word
);
    import s1h_pkg::*;

    typedef enum logic [2:0] {
        S_RUN, S_PAD, S_DRAIN, S_RD, S_CAP, S_WAIT
    } fsm_state_t;

    fsm_state_t       state_reg;
    logic [5:0]       fill_reg;          // bytes in the current block
    logic [63:0]      bit_count_reg;     // message length in bits
    logic             wbank_reg;         // bank being filled
    logic             cbank_reg;         // next bank for the core
    logic [1:0]       busy_reg;          // bank full, waiting for or in compression
    logic [1:0]       busy_next;
    logic             pad_first_reg;     // next pad byte is the 0x80 marker
    logic             len_phase_reg;     // pad is writing the length bytes
    logic [H_AW-1:0]  idx_reg;           // digest word being emitted
    logic             m_tvalid_reg;
    logic             m_tlast_reg;
    logic [31:0]      m_word_reg;
    logic [H_AW-1:0]  m_index_reg;

    logic             space;
    logic             in_acc;
    logic             pad_put;
    logic             put;
    logic [7:0]       pad_byte;
    logic             block_full;
    logic             restart;

    buf_wr_t          buf_wr;
    core_ctrl_t       core_ctrl;
    core_stat_t       core_stat;
    logic [BUF_AW-1:0] msg_addr;
    logic [31:0]      msg_data;
    logic [31:0]      dig_data;

    // the bank being written must not be waiting for the core
    assign space    = !busy_reg[wbank_reg];
    assign s_tready = (state_reg == S_RUN) && space;
    assign in_acc   = s_tvalid && s_tready;
    assign pad_put  = (state_reg == S_PAD) && space;
    assign put      = (in_acc && !s_tuser) || pad_put;

    // length bytes go out most significant first at positions 56..63
    always_comb begin
        if (pad_first_reg) begin
            pad_byte = PAD_MARK;
        end else if (len_phase_reg) begin
            pad_byte = bit_count_reg[{~fill_reg[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    assign block_full = put && (fill_reg == BLOCK_END);

    assign buf_wr.en   = put;
    assign buf_wr.bank = wbank_reg;
    assign buf_wr.pos  = fill_reg;
    assign buf_wr.data = pad_put ? pad_byte : s_tdata;

    // last digest word taken: return to the initial chaining values
    assign restart = (state_reg == S_WAIT) && m_tready && (idx_reg == LAST_WORD);

    assign core_ctrl.start   = core_stat.idle && busy_reg[cbank_reg];
    assign core_ctrl.bank    = cbank_reg;
    assign core_ctrl.restart = restart;

    // full-bank flags: set by the filler, cleared when the core finishes
    always_comb begin
        busy_next = busy_reg;
        if (core_stat.done) begin
            busy_next[cbank_reg] = 1'b0;
        end
        if (block_full) begin
            busy_next[wbank_reg] = 1'b1;
        end
    end

    s1h_msg_buf u_buf (
        .aclk    (aclk),
        .wr      (buf_wr),
        .rd_addr (msg_addr),
        .rd_data (msg_data)
    );

    s1h_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (core_ctrl),
        .stat     (core_stat),
        .msg_addr (msg_addr),
        .msg_data (msg_data),
        .dig_addr (idx_reg),
        .dig_data (dig_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_RUN;
            fill_reg      <= '0;
            bit_count_reg <= '0;
            wbank_reg     <= 1'b0;
            cbank_reg     <= 1'b0;
            busy_reg      <= '0;
            pad_first_reg <= 1'b0;
            len_phase_reg <= 1'b0;
            idx_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tlast_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            if (core_stat.done) begin
                cbank_reg <= !cbank_reg;
            end
            if (put) begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (block_full) begin
                wbank_reg <= !wbank_reg;
            end

            case (state_reg)
                S_RUN: begin
                    if (in_acc) begin
                        if (s_tuser) begin
                            pad_first_reg <= 1'b1;
                            len_phase_reg <= 1'b0;
                            state_reg     <= S_PAD;
                        end else begin
                            bit_count_reg <= bit_count_reg + 64'd8;
                        end
                    end
                end
                S_PAD: begin
                    if (pad_put) begin
                        pad_first_reg <= 1'b0;
                        if (len_phase_reg && fill_reg == BLOCK_END) begin
                            len_phase_reg <= 1'b0;
                            state_reg     <= S_DRAIN;
                        end else if (!len_phase_reg && (fill_reg + 6'd1) == LEN_POS) begin
                            len_phase_reg <= 1'b1;
                        end
                    end
                end
                S_DRAIN: begin
                    // all padded blocks compressed
                    if (busy_reg == 2'b00 && core_stat.idle) begin
                        idx_reg   <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD: begin
                    state_reg <= S_CAP;
                end
                S_CAP: begin
                    m_word_reg   <= dig_data;
                    m_index_reg  <= idx_reg;
                    m_tlast_reg  <= (idx_reg == LAST_WORD);
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_WAIT;
                end
                S_WAIT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (idx_reg == LAST_WORD) begin
                            idx_reg       <= '0;
                            bit_count_reg <= '0;
                            state_reg     <= S_RUN;
                        end else begin
                            idx_reg   <= idx_reg + H_AW'(1);
                            state_reg <= S_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_RUN;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {5'b00000, m_word_reg, m_index_reg};

`ifndef SYNTHESIS
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        core_stat.done |-> busy_reg[cbank_reg])
        else $error("core finished a bank not marked full");

    a_read_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD) |-> (busy_reg == 2'b00 && core_stat.idle))
        else $error("digest read before compression finished");

    a_restart_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        restart |=> (fill_reg == 6'd0 && bit_count_reg == 64'd0))
        else $error("message state not cleared after digest");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[2:0] == LAST_WORD)))
        else $error("last flag does not match word index");
`endif

endmodule

`default_nettype wire

[rtl/s1h_msg_buf.sv]
// two-bank message block buffer with byte-to-word packing
`default_nettype none

module s1h_msg_buf (
    input  wire logic                   aclk,
    input  wire s1h_pkg::buf_wr_t       wr,
    input  wire logic [s1h_pkg::BUF_AW-1:0] rd_addr,
    output logic [31:0]                 rd_data
);
    import s1h_pkg::*;

    logic [23:0] acc_reg;
    logic [31:0] mem [0:BUF_WORDS-1];

    // big-endian packing, word written on its fourth byte
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            case (wr.pos[1:0])
                2'd0:    acc_reg[23:16] <= wr.data;
                2'd1:    acc_reg[15:8]  <= wr.data;
                2'd2:    acc_reg[7:0]   <= wr.data;
                default: mem[{wr.bank, wr.pos[5:2]}] <= {acc_reg, wr.data};
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/s1h_core.sv]
// sha-1 compression core with chaining-word memory and message schedule
`default_nettype none

module s1h_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire s1h_pkg::core_ctrl_t        ctrl,
    output s1h_pkg::core_stat_t             stat,
    output logic [s1h_pkg::BUF_AW-1:0]      msg_addr,
    input  wire logic [31:0]                msg_data,
    input  wire logic [s1h_pkg::H_AW-1:0]   dig_addr,
    output logic [31:0]                     dig_data
);
    import s1h_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_LOAD, C_ROUND, C_WB} core_state_t;

    core_state_t      state_reg;
    logic [H_AW-1:0]  cnt_reg;
    logic [RND_W-1:0] rnd_reg;
    logic             bank_reg;
    logic             fresh_reg;
    logic [31:0]      a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]      sched_reg [0:BANK_WORDS-1];

    logic [31:0]      chain_mem [0:NUM_H-1];
    logic [31:0]      chain_rdata_reg;
    logic [H_AW-1:0]  chain_raddr;
    logic [H_AW-1:0]  prev_idx;
    logic [31:0]      h_val;
    logic [31:0]      w_mix;
    logic [31:0]      w_t;
    logic [31:0]      t_sum;
    logic             wb_wr;

    assign chain_raddr = (state_reg == C_IDLE) ? dig_addr : cnt_reg;
    assign prev_idx    = cnt_reg - H_AW'(1);
    // chaining words read as the initial values until the first write-back
    assign h_val       = fresh_reg ? init_word(prev_idx) : chain_rdata_reg;
    assign wb_wr       = (state_reg == C_WB) && (cnt_reg != '0);
    assign dig_data    = chain_rdata_reg;

    assign w_mix = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
    assign w_t   = (rnd_reg < RND_W'(BANK_WORDS)) ? msg_data : {w_mix[30:0], w_mix[31]};
    assign t_sum = {a_reg[26:0], a_reg[31:27]} + round_f(rnd_reg, b_reg, c_reg, d_reg)
                 + e_reg + round_k(rnd_reg) + w_t;

    // word for the next round is addressed in the cycle before, through the buffer's registered read
    assign msg_addr = {bank_reg, (state_reg == C_LOAD) ? 4'd0 : (rnd_reg[3:0] + 4'd1)};

    assign stat.idle = (state_reg == C_IDLE);
    assign stat.done = (state_reg == C_WB) && (cnt_reg == LAST_WORD + H_AW'(1));

    always_ff @(posedge aclk) begin
        chain_rdata_reg <= chain_mem[chain_raddr];
        if (wb_wr) begin
            chain_mem[prev_idx] <= h_val + a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            fresh_reg <= 1'b1;
            cnt_reg   <= '0;
            rnd_reg   <= '0;
            bank_reg  <= 1'b0;
        end else begin
            case (state_reg)
                C_IDLE: begin
                    if (ctrl.restart) begin
                        fresh_reg <= 1'b1;
                    end
                    if (ctrl.start) begin
                        bank_reg  <= ctrl.bank;
                        cnt_reg   <= '0;
                        state_reg <= C_LOAD;
                    end
                end
                C_LOAD: begin
                    cnt_reg <= cnt_reg + H_AW'(1);
                    if (cnt_reg != '0) begin
                        {a_reg, b_reg, c_reg, d_reg, e_reg} <=
                            {b_reg, c_reg, d_reg, e_reg, h_val};
                    end
                    if (cnt_reg == LAST_WORD + H_AW'(1)) begin
                        rnd_reg   <= '0;
                        state_reg <= C_ROUND;
                    end
                end
                C_ROUND: begin
                    e_reg   <= d_reg;
                    d_reg   <= c_reg;
                    c_reg   <= {b_reg[1:0], b_reg[31:2]};
                    b_reg   <= a_reg;
                    a_reg   <= t_sum;
                    rnd_reg <= rnd_reg + RND_W'(1);
                    for (int j = 0; j < BANK_WORDS - 1; j++) begin
                        sched_reg[j] <= sched_reg[j+1];
                    end
                    sched_reg[BANK_WORDS-1] <= w_t;
                    if (rnd_reg == RND_W'(ROUNDS - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= C_WB;
                    end
                end
                C_WB: begin
                    cnt_reg <= cnt_reg + H_AW'(1);
                    if (cnt_reg != '0) begin
                        {a_reg, b_reg, c_reg, d_reg, e_reg} <=
                            {b_reg, c_reg, d_reg, e_reg, a_reg};
                    end
                    if (cnt_reg == LAST_WORD + H_AW'(1)) begin
                        fresh_reg <= 1'b0;
                        state_reg <= C_IDLE;
                    end
                end
                default: begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |-> (state_reg == C_IDLE))
        else $error("core started while busy");

    a_round_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == C_ROUND && rnd_reg == '0) |-> ($past(state_reg) == C_LOAD))
        else $error("round zero not preceded by chaining load");
`endif

endmodule

`default_nettype wire

[dv/sha1_stream_hasher_tb.sv]
// self-checking testbench of the sha-1 stream hasher: directed and random messages against a digest predictor
`default_nettype none

module sha1_stream_hasher_tb;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;
    localparam int   SETTLE_CYCLES = 300;   // covers padding plus two compressions
    localparam int   PHASE_WORDS   = 74;
    localparam logic [31:0] SHA1_IV [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    typedef struct {
        logic [2:0]  index;
        logic [31:0] word;
        logic        last;
    } digest_entry_t;

    // running sha-1 of the accepted byte stream and the digest words still owed
    class digest_scoreboard;
        logic [31:0]   chain[5];
        logic [7:0]    blk[64];
        logic [5:0]    fill;
        logic [63:0]   msg_bits;
        digest_entry_t pending_digest[$];
        int            mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            chain    = SHA1_IV;
            fill     = 6'd0;
            msg_bits = 64'd0;
        endfunction

        function void compress();
            logic [31:0] w[80];
            logic [31:0] a, b, c, d, e, f, k, t;
            for (int i = 0; i < 16; i++) begin
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            end
            for (int i = 16; i < 80; i++) begin
                t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
                w[i] = {t[30:0], t[31]};
            end
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
            for (int i = 0; i < 80; i++) begin
                if (i < 20) begin
                    f = (b & c) | (~b & d);
                    k = s1h_pkg::K_0;
                end else if (i < 40) begin
                    f = b ^ c ^ d;
                    k = s1h_pkg::K_1;
                end else if (i < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = s1h_pkg::K_2;
                end else begin
                    f = b ^ c ^ d;
                    k = s1h_pkg::K_3;
                end
                t = {a[26:0], a[31:27]} + f + e + k + w[i];
                e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
        endfunction

        function void absorb(logic [7:0] x);
            blk[fill] = x;
            fill = fill + 6'd1;
            if (fill == 6'd0) begin
                compress();
            end
        endfunction

        // one accepted input word
        function void note_word(logic kind, logic [7:0] data);
            logic [63:0]   len;
            digest_entry_t ent;
            if (kind == KIND_BYTE) begin
                msg_bits += 64'd8;
                absorb(data);
            end else begin
                // data byte is don't-care on finish
                len = msg_bits;
                absorb(s1h_pkg::PAD_MARK);
                while (fill != s1h_pkg::LEN_POS) begin
                    absorb(8'h00);
                end
                for (int i = 0; i < 8; i++) begin
                    absorb(len[63-8*i -: 8]);
                end
                for (int i = 0; i < s1h_pkg::NUM_H; i++) begin
                    ent.index = 3'(i);
                    ent.word  = chain[i];
                    ent.last  = (3'(i) == s1h_pkg::LAST_WORD);
                    pending_digest = {pending_digest, ent};
                end
                restart();
            end
        endfunction

        function void flag(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("digest mismatch on %s: expected %h, got %h", field, want, got);
            end
        endfunction

        // one accepted result word
        function void check_word(logic [2:0] index, logic [31:0] word, logic last);
            digest_entry_t want;
            if (pending_digest.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("stray digest word: index %0d word %h last %b", index, word, last);
                end
                return;
            end
            want = pending_digest.pop_front();
            if (index !== want.index) flag("word_index", 32'(want.index), 32'(index));
            if (word !== want.word)   flag("digest_word", want.word, word);
            if (last !== want.last)   flag("last", 32'(want.last), 32'(last));
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    digest_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int sent_words    = 0;

    sha1_stream_hasher u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (($urandom % 100) >= stall_pct);
        end
    end

    // digest word monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_word(m_tdata[2:0], m_tdata[34:3], m_tlast);
        end
    end

    task automatic send_word(input logic kind, input logic [7:0] data);
        while (($urandom % 100) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(kind, data);
        sent_words++;
    endtask

    task automatic send_message(input int n_bytes);
        for (int i = 0; i < n_bytes; i++) begin
            send_word(KIND_BYTE, 8'($urandom_range(0, 255)));
        end
        send_word(KIND_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // hold off the sender until every owed digest word has left
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_digest.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int phase_start;
        int n_bytes;
        int edge_len[4];
        int idle_set[4];
        int stall_set[4];
        edge_len  = '{55, 56, 63, 64};
        idle_set  = '{0, 77, 0, 6};
        stall_set = '{0, 0, 77, 6};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty message with a junk byte on finish, "abc",
        // byte extremes, back-to-back finishes
        send_word(KIND_FINISH, 8'hff);
        send_word(KIND_BYTE, 8'h61);
        send_word(KIND_BYTE, 8'h62);
        send_word(KIND_BYTE, 8'h63);
        send_word(KIND_FINISH, 8'h00);
        send_word(KIND_BYTE, 8'h00);
        send_word(KIND_BYTE, 8'hff);
        send_word(KIND_FINISH, 8'h55);
        send_word(KIND_FINISH, 8'haa);
        send_word(KIND_FINISH, 8'h00);
        drain();

        // random messages under four idling mixes; each phase opens with a
        // length at a padding boundary (one block, spill into two, full blocks)
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_set[p];
            stall_pct     = stall_set[p];
            phase_start   = sent_words;
            send_message(edge_len[p]);
            while (sent_words - phase_start < PHASE_WORDS) begin
                if ($urandom_range(0, 9) == 0) begin
                    n_bytes = edge_len[$urandom_range(0, 3)];
                end else begin
                    n_bytes = $urandom_range(0, 20);
                end
                send_message(n_bytes);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_digest.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/s1h_pkg.sv
rtl/s1h_msg_buf.sv
rtl/s1h_core.sv
rtl/sha1_stream_hasher.sv
dv/sha1_stream_hasher_tb.sv
